// File: rtl/tpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpts_pkg
// Widths, command codes and phase codes for the tone pulse-train sequencer.
// ----------------------------------------------------------------------------
package tpts_pkg;

    localparam int TIME_W    = 24;
    localparam int FREQ_W    = 16;
    localparam int REPEAT_W  = 16;
    localparam int PERIOD_W  = 16;
    localparam int ELAPSED_W = TIME_W + 2;
    localparam int CYCLE_W   = TIME_W + 1;

    localparam int CMD_W     = 2;
    localparam int IN_DATA_W = 80;   // tone, on, off, repeat = 80 bits
    localparam int OUT_DATA_W = 24;  // freq, changed, busy = 18 bits, padded

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [FREQ_W-1:0]    freq_t;
    typedef logic [REPEAT_W-1:0]  repeat_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [CYCLE_W-1:0]   cycle_t;
    typedef logic [1:0]           phase_t;

    localparam cmd_t CMD_TICK    = 2'd0;
    localparam cmd_t CMD_TONE    = 2'd1;
    localparam cmd_t CMD_SILENCE = 2'd2;
    localparam cmd_t CMD_PATTERN = 2'd3;

    localparam phase_t PH_NEW  = 2'd0;
    localparam phase_t PH_ON   = 2'd1;
    localparam phase_t PH_OFF  = 2'd2;
    localparam phase_t PH_IDLE = 2'd3;

endpackage : tpts_pkg
`default_nettype wire

// File: rtl/tone_pulse_train_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_pulse_train_sequencer
// Single-channel buzzer sequencer: continuous tone, silence or pulse train.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries commands: s_tuser is the command (tick, tone,
//   silence, pattern), s_tdata the pattern fields. Every accepted transfer
//   yields exactly one master-stream (m_*) transfer with the drive frequency,
//   a changed flag and a busy flag.
//   Result valid follows in the cycle after the input transfer. Throughput:
//   one transfer per cycle unless m_tready stalls; the sequencer state and
//   the result register are updated in the same edge, the tick path being
//   one 26-bit add, a compare against the cycle length and a subtract.
//   The result register is the only buffering: s_tready is high whenever
//   that register is empty or is being emptied, so a stall on m_tready
//   backs up into s_tready after one held result.
//   tick_period is written through tick_period_we/tick_period_wdata; the
//   user writes it only while the block is idle (unenforced); it resets to 1.
//   Reset: phase idle, nothing pending, drive 0, result register empty.
// ----------------------------------------------------------------------------
module tone_pulse_train_sequencer
    import tpts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_period_we,
    input  wire logic [PERIOD_W-1:0]   tick_period_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] tone_freq, [39:16] on_time, [63:40] off_time, [79:64] repeat_count
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]      s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] drive_freq, [16] drive_changed, [17] busy_res, [23:18] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [PERIOD_W-1:0] tick_period_reg;
    phase_t   phase_reg, phase_next;
    logic     pending_reg, pending_next;
    elapsed_t elapsed_reg, elapsed_next;
    time_t    on_time_reg, on_time_next;
    time_t    off_time_reg, off_time_next;
    repeat_t  repeats_reg, repeats_next;
    freq_t    tone_reg, tone_next;
    freq_t    drive_reg, drive_next;
    logic     changed_next;

    logic     out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    cmd_t     cmd;
    freq_t    in_tone;
    time_t    in_on;
    time_t    in_off;
    repeat_t  in_repeat;
    logic     accept;

    phase_t   cur_phase;
    cycle_t   cycle;
    elapsed_t elapsed_sum;

    assign cmd       = s_tuser;
    assign in_tone   = s_tdata[15:0];
    assign in_on     = s_tdata[39:16];
    assign in_off    = s_tdata[63:40];
    assign in_repeat = s_tdata[79:64];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cycle       = {1'b0, on_time_reg} + {1'b0, off_time_reg};
    assign elapsed_sum = elapsed_reg + ELAPSED_W'(tick_period_reg);
    // a pending pattern restarts at the new-cycle phase
    assign cur_phase   = pending_reg ? PH_NEW : phase_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        elapsed_next  = elapsed_reg;
        on_time_next  = on_time_reg;
        off_time_next = off_time_reg;
        repeats_next  = repeats_reg;
        tone_next     = tone_reg;
        drive_next    = drive_reg;
        changed_next  = 1'b0;

        unique case (cmd)
            CMD_TONE:
            begin
                on_time_next  = TIME_W'(1);
                off_time_next = '0;
                repeats_next  = '0;
                tone_next     = in_tone;
                pending_next  = 1'b1;
            end
            CMD_SILENCE:
            begin
                on_time_next  = '0;
                off_time_next = '0;
                repeats_next  = '0;
                tone_next     = '0;
                pending_next  = 1'b1;
            end
            CMD_PATTERN:
            begin
                on_time_next  = in_on;
                off_time_next = in_off;
                repeats_next  = in_repeat;
                tone_next     = in_tone;
                pending_next  = 1'b1;
            end
            default:
            begin
                pending_next = 1'b0;
                unique case (cur_phase)
                    PH_NEW:
                    begin
                        changed_next = 1'b1;
                        if (on_time_reg != '0)
                        begin
                            drive_next = tone_reg;
                            if (off_time_reg != '0)
                            begin
                                elapsed_next = '0;
                                phase_next   = PH_ON;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            drive_next = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ON:
                    begin
                        elapsed_next = elapsed_sum;
                        if (elapsed_sum >= ELAPSED_W'(on_time_reg))
                        begin
                            drive_next   = '0;
                            changed_next = 1'b1;
                            phase_next   = PH_OFF;
                        end
                        else
                        begin
                            phase_next = PH_ON;
                        end
                    end
                    PH_OFF:
                    begin
                        elapsed_next = elapsed_sum;
                        if (elapsed_sum >= ELAPSED_W'(cycle))
                        begin
                            // keep the overshoot for the next cycle
                            elapsed_next = elapsed_sum - ELAPSED_W'(cycle);
                            changed_next = 1'b1;
                            if (repeats_reg == REPEAT_W'(1))
                            begin
                                drive_next = '0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                drive_next = tone_reg;
                                if (repeats_reg != '0)
                                begin
                                    repeats_next = repeats_reg - REPEAT_W'(1);
                                end
                                phase_next = PH_ON;
                            end
                        end
                        else
                        begin
                            phase_next = PH_OFF;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        endcase

        out_data_next = {(OUT_DATA_W - FREQ_W - 2)'(0),
                         (pending_next || (phase_next != PH_IDLE)),
                         changed_next,
                         drive_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= PERIOD_W'(1);
            phase_reg       <= PH_IDLE;
            pending_reg     <= 1'b0;
            elapsed_reg     <= '0;
            on_time_reg     <= '0;
            off_time_reg    <= '0;
            repeats_reg     <= '0;
            tone_reg        <= '0;
            drive_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (tick_period_we)
            begin
                tick_period_reg <= tick_period_wdata;
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                pending_reg   <= pending_next;
                elapsed_reg   <= elapsed_next;
                on_time_reg   <= on_time_next;
                off_time_reg  <= off_time_next;
                repeats_reg   <= repeats_next;
                tone_reg      <= tone_next;
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule : tone_pulse_train_sequencer
`default_nettype wire

// File: test/tpts_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpts_drive_checker
// Watches both streams and the tick_period write port of the tone pulse-train
// sequencer. It keeps its own copy of the sequencer state and predicts the
// drive result of every accepted input transfer. Each output transfer is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tpts_drive_checker
    import tpts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_period_we,
    input  wire logic [PERIOD_W-1:0]   tick_period_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [CMD_W-1:0]      s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int                         errors,
    output int                         outstanding,
    output int                         results_seen
);

    typedef struct {
        freq_t drive_freq;
        logic  drive_changed;
        logic  busy;
    } drive_result_t;

    drive_result_t expected_drive_q[$];

    // shadow of the sequencer
    logic [PERIOD_W-1:0] period_now;
    phase_t              seq_phase;
    logic                restart_pending;
    elapsed_t            elapsed_units;
    time_t               on_len;
    time_t               off_len;
    repeat_t             cycles_left;
    freq_t               tone_hold;
    freq_t               drive_now;

    initial
    begin
        errors       = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (errors < 40)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic drive_result_t sequence_step(input cmd_t cmd,
                                                    input logic [IN_DATA_W-1:0] d);
        drive_result_t res;
        cycle_t        cyc;
        res.drive_changed = 1'b0;
        case (cmd)
            CMD_TONE:
            begin
                on_len          = time_t'(1);
                off_len         = '0;
                cycles_left     = '0;
                tone_hold       = d[15:0];
                restart_pending = 1'b1;
            end
            CMD_SILENCE:
            begin
                on_len          = '0;
                off_len         = '0;
                cycles_left     = '0;
                tone_hold       = '0;
                restart_pending = 1'b1;
            end
            CMD_PATTERN:
            begin
                tone_hold       = d[15:0];
                on_len          = d[39:16];
                off_len         = d[63:40];
                cycles_left     = d[79:64];
                restart_pending = 1'b1;
            end
            default:
            begin
                cyc = cycle_t'(on_len) + cycle_t'(off_len);
                if (restart_pending)
                begin
                    restart_pending = 1'b0;
                    seq_phase       = PH_NEW;
                end
                case (seq_phase)
                    PH_NEW:
                    begin
                        res.drive_changed = 1'b1;
                        if (on_len != '0)
                        begin
                            drive_now = tone_hold;
                            if (off_len != '0)
                            begin
                                elapsed_units = '0;
                                seq_phase     = PH_ON;
                            end
                            else
                                seq_phase = PH_IDLE;
                        end
                        else
                        begin
                            drive_now = '0;
                            seq_phase = PH_IDLE;
                        end
                    end
                    PH_ON:
                    begin
                        elapsed_units = elapsed_units + elapsed_t'(period_now);
                        if (elapsed_units >= elapsed_t'(on_len))
                        begin
                            drive_now         = '0;
                            res.drive_changed = 1'b1;
                            seq_phase         = PH_OFF;
                        end
                    end
                    PH_OFF:
                    begin
                        elapsed_units = elapsed_units + elapsed_t'(period_now);
                        if (elapsed_units >= elapsed_t'(cyc))
                        begin
                            // overshoot carries into the next cycle
                            elapsed_units     = elapsed_units - elapsed_t'(cyc);
                            res.drive_changed = 1'b1;
                            if (cycles_left == repeat_t'(1))
                            begin
                                drive_now = '0;
                                seq_phase = PH_IDLE;
                            end
                            else
                            begin
                                drive_now = tone_hold;
                                if (cycles_left != '0)
                                    cycles_left = cycles_left - repeat_t'(1);
                                seq_phase = PH_ON;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        res.drive_freq = drive_now;
        res.busy       = restart_pending || (seq_phase != PH_IDLE);
        return res;
    endfunction

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        drive_result_t want;
        results_seen++;
        if (expected_drive_q.size() == 0)
        begin
            report_mismatch("transfer with nothing expected", 64'(d), 64'(0));
            return;
        end
        want = expected_drive_q.pop_front();
        if (d[15:0] !== want.drive_freq)
            report_mismatch("drive_freq", 64'(d[15:0]), 64'(want.drive_freq));
        if (d[16] !== want.drive_changed)
            report_mismatch("drive_changed", 64'(d[16]), 64'(want.drive_changed));
        if (d[17] !== want.busy)
            report_mismatch("busy_res", 64'(d[17]), 64'(want.busy));
        if (d[OUT_DATA_W-1:18] !== '0)
            report_mismatch("tdata padding", 64'(d[OUT_DATA_W-1:18]), 64'(0));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_now      = PERIOD_W'(1);
            seq_phase       = PH_IDLE;
            restart_pending = 1'b0;
            elapsed_units   = '0;
            on_len          = '0;
            off_len         = '0;
            cycles_left     = '0;
            tone_hold       = '0;
            drive_now       = '0;
            expected_drive_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (tick_period_we)
                period_now = tick_period_wdata;
            if (s_tvalid && s_tready)
                expected_drive_q.push_back(sequence_step(s_tuser, s_tdata));
            outstanding <= expected_drive_q.size();
        end
    end

endmodule : tpts_drive_checker

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the tone pulse-train sequencer: a directed pass over tone,
// silence, pattern corner cases, then pattern/tick bursts with random content
// under several tick periods, with random idling on both streams, a long
// receiver stall and a full drain. Checking is done by tpts_drive_checker.
// ----------------------------------------------------------------------------
module testbench;
    import tpts_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int ITEMS_PER_STEP = 230;

    logic                  clk;
    logic                  rst_n;
    logic                  tick_period_we;
    logic [PERIOD_W-1:0]   tick_period_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int   errors;
    int   outstanding;
    int   results_seen;
    int   n_sent;
    int   n_cmd [4];
    logic steady_flow;
    logic hold_rx;

    tone_pulse_train_sequencer u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick_period_we    (tick_period_we),
        .tick_period_wdata (tick_period_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

    tpts_drive_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick_period_we    (tick_period_we),
        .tick_period_wdata (tick_period_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .errors            (errors),
        .outstanding       (outstanding),
        .results_seen      (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[tone_pulse_train_sequencer] ERROR");
        $finish;
    end

    // result side: random back-pressure, or a long hold when asked
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
                m_tready <= steady_flow || ($urandom_range(99) >= 28);
        end
    end

    // s_tvalid stays high on return so back-to-back transfers need no toggle
    task automatic send_item(input cmd_t c, input freq_t f, input time_t on_t,
                             input time_t off_t, input repeat_t r);
        if (!steady_flow)
            while ($urandom_range(99) < 28)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {r, off_t, on_t, f};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
        n_cmd[c]++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, freq_t'($urandom), time_t'($urandom), time_t'($urandom),
                  repeat_t'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_tick_period(input logic [PERIOD_W-1:0] v);
        tick_period_we    <= 1'b1;
        tick_period_wdata <= v;
        @(posedge clk);
        tick_period_we    <= 1'b0;
    endtask

    // a command with random content followed by a run of ticks, or a bit of noise
    task automatic play_burst(input int unsigned period);
        int unsigned unit;
        int unsigned pick;
        time_t       on_t;
        time_t       off_t;
        unit = (period == 0) ? 1 : period;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 4))
                send_item(cmd_t'($urandom_range(3)), freq_t'($urandom), time_t'($urandom),
                          time_t'($urandom), repeat_t'($urandom));
        end
        else
        begin
            if (pick < 72)
            begin
                on_t  = ($urandom_range(9) == 0) ? '0 : time_t'($urandom_range(1, 6 * unit));
                off_t = ($urandom_range(9) == 0) ? '0 : time_t'($urandom_range(1, 6 * unit));
                send_item(CMD_PATTERN, freq_t'($urandom), on_t, off_t,
                          repeat_t'($urandom_range(0, 4)));
            end
            else if (pick < 86)
                send_item(CMD_TONE, freq_t'($urandom), time_t'($urandom), time_t'($urandom),
                          repeat_t'($urandom));
            else
                send_item(CMD_SILENCE, freq_t'($urandom), time_t'($urandom),
                          time_t'($urandom), repeat_t'($urandom));
            repeat ($urandom_range(1, 30))
                send_tick();
        end
    endtask

    initial
    begin
        int unsigned periods [5];
        int          stop_at;
        int          mid;
        rst_n             <= 1'b0;
        s_tvalid          <= 1'b0;
        s_tdata           <= '0;
        s_tuser           <= CMD_TICK;
        tick_period_we    <= 1'b0;
        tick_period_wdata <= '0;
        steady_flow        = 1'b0;
        hold_rx            = 1'b0;
        n_sent             = 0;
        n_cmd              = '{default: 0};
        periods            = '{1, 65535, 0, 7, 0};
        periods[4]         = $urandom_range(2, 300);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        set_tick_period(PERIOD_W'(1));
        send_item(CMD_TICK, '1, '1, '1, '1);                          // idle tick
        send_item(CMD_TONE, '1, '1, '1, '1);                          // on, off and repeat ignored
        send_tick();
        send_item(CMD_SILENCE, '1, '1, '1, '1);
        send_tick();
        send_item(CMD_PATTERN, 16'h1234, '0, time_t'(5), repeat_t'(3));  // no on time
        send_tick();
        send_item(CMD_PATTERN, 16'hABCD, time_t'(3), '0, repeat_t'(2));  // no off time
        send_tick();
        send_item(CMD_PATTERN, 16'h0F0F, time_t'(1), time_t'(1), repeat_t'(1));
        repeat (4) send_tick();
        send_item(CMD_PATTERN, 16'h00FF, time_t'(2), time_t'(1), '0);    // forever
        repeat (5) send_tick();
        send_item(CMD_PATTERN, '1, '1, '1, '1);
        repeat (2) send_tick();
        send_item(CMD_SILENCE, '0, '0, '0, '0);
        send_tick();

        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            set_tick_period(PERIOD_W'(periods[p]));
            steady_flow = (p == 2);
            stop_at     = n_sent + ITEMS_PER_STEP;
            mid         = n_sent + ITEMS_PER_STEP / 2;
            while (n_sent < stop_at)
            begin
                if (mid > 0 && n_sent >= mid)
                begin
                    mid = 0;
                    if (p == 1)
                        hold_rx = 1'b1;        // fill the block while offering transfers
                    else if (p == 3)
                        drain_results();
                end
                play_burst(periods[p]);
            end
        end
        steady_flow = 1'b0;
        drain_results();
        repeat (4) @(posedge clk);

        $display("covered %0d ticks, %0d tone, %0d silence and %0d pattern commands",
                 n_cmd[CMD_TICK], n_cmd[CMD_TONE], n_cmd[CMD_SILENCE], n_cmd[CMD_PATTERN]);
        $display("%0d results checked over tick periods 1, 65535, 0, 7 and %0d",
                 results_seen, periods[4]);
        if (errors == 0 && outstanding == 0)
            $display("[tone_pulse_train_sequencer] OK");
        else
            $display("[tone_pulse_train_sequencer] ERROR");
        $finish;
    end

endmodule : testbench
